>>> design/adsc_pkg.sv
// Shared types, widths, constants and helpers for the adaptive soft clipper.
package adsc_pkg;

  localparam int SMP_W  = 24;  // Q4.20 sample
  localparam int DRV_W  = 20;  // Q4.16 drive
  localparam int GAIN_W = 17;  // Q1.16 / Q0.16 controls
  localparam int ENV_W  = 28;  // Q8.20 magnitudes
  localparam int COEF_W = 24;  // Q0.24 coefficients
  localparam int C20_W  = 21;  // ceiling in Q.20
  localparam int KNEE_W = 16;
  localparam int NRG_W  = 32;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [COEF_W-1:0] SMOOTH_COEF_DEF       = 24'd16768480;
  localparam logic [COEF_W-1:0] FAST_ATTACK_COEF_DEF  = 24'd16285142;
  localparam logic [COEF_W-1:0] FAST_RELEASE_COEF_DEF = 24'd16767510;
  localparam logic [COEF_W-1:0] BODY_ATTACK_COEF_DEF  = 24'd16762659;

  localparam logic [GAIN_W-1:0] Q16_ONE = 17'd65536;

  // register index codes
  localparam logic [2:0] REG_DRIVE   = 3'd0;
  localparam logic [2:0] REG_CEILING = 3'd1;
  localparam logic [2:0] REG_SHAPE   = 3'd2;
  localparam logic [2:0] REG_BIAS    = 3'd3;
  localparam logic [2:0] REG_LINK    = 3'd4;
  localparam logic [2:0] REG_TRIM    = 3'd5;
  localparam logic [2:0] REG_BODYREL = 3'd6;
  localparam logic [2:0] REG_MONO    = 3'd7;

  typedef struct packed {
    logic start;
    logic en;      // channel is processed: envelopes update
  } lane_cmd_t;

  typedef struct packed {
    logic              done;
    logic [ENV_W-1:0]  fast;
    logic [ENV_W-1:0]  body;
    logic [C20_W-1:0]  shaped;
    logic [GAIN_W-1:0] cls;
    logic [KNEE_W-1:0] knee;
    logic [NRG_W-1:0]  eterm;
  } lane_res_t;

  // one-pole step toward t: t +/- floor(|s-t|*c/2^24)
  function automatic logic [ENV_W-1:0] smooth_to(input logic [ENV_W-1:0] s,
                                                 input logic [ENV_W-1:0] t,
                                                 input logic [COEF_W-1:0] c);
    logic [ENV_W-1:0]        d;
    logic [ENV_W+COEF_W-1:0] p;
    d = (s >= t) ? (s - t) : (t - s);
    p = d * c;
    if (s >= t) begin
      return t + p[ENV_W+COEF_W-1:COEF_W];
    end
    return t - p[ENV_W+COEF_W-1:COEF_W];
  endfunction

  function automatic logic [GAIN_W-1:0] cap16(input logic [GAIN_W-1:0] v);
    return (v > Q16_ONE) ? Q16_ONE : v;
  endfunction

endpackage

>>> design/adsc_div.sv
// Restoring serial divider, one quotient bit per cycle.
module adsc_div import adsc_pkg::*; #(
  parameter int DW = 32,
  parameter int QW = 19
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DW+QW-1:0] num,   // num >> QW must be below den
  input  logic [DW-1:0]    den,
  output logic             done,
  output logic [QW-1:0]    quo
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [QW-1:0] low_r;
  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   rem_nxt;

  always_comb begin
    trial   = {rem_r, low_r[QW-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= ~start & (cnt_r == CW'(1));
      if (start) begin
        cnt_r <= CW'(QW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[DW+QW-1:QW];
      low_r <= num[QW-1:0];
      den_r <= den;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt[DW-1:0];
      low_r <= {low_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = low_r;

endmodule

>>> design/adsc_lane.sv
// One channel lane: envelopes, link blend, class, knee and tanh shaping.
module adsc_lane import adsc_pkg::*; #(
  parameter logic [COEF_W-1:0] FAST_ATTACK_COEF  = FAST_ATTACK_COEF_DEF,
  parameter logic [COEF_W-1:0] FAST_RELEASE_COEF = FAST_RELEASE_COEF_DEF,
  parameter logic [COEF_W-1:0] BODY_ATTACK_COEF  = BODY_ATTACK_COEF_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lane_cmd_t         cmd,
  input  logic [SMP_W-1:0]  sample,
  input  logic [DRV_W-1:0]  drive,
  input  logic [COEF_W-1:0] body_rel,
  input  logic [ENV_W-1:0]  lf,
  input  logic [ENV_W-1:0]  lb,
  input  logic [GAIN_W-1:0] link,
  input  logic [GAIN_W-1:0] shape,
  input  logic [GAIN_W-1:0] bias,
  input  logic [C20_W-1:0]  ceil20,
  output lane_res_t         res
);

  localparam int DDW = 32;
  localparam int DQW = 19;

  localparam logic [4:0] L_DONE  = 5'd0;
  localparam logic [4:0] L_MAG   = 5'd1;
  localparam logic [4:0] L_ENV   = 5'd2;
  localparam logic [4:0] L_BLEND = 5'd3;
  localparam logic [4:0] L_CLS   = 5'd4;
  localparam logic [4:0] L_CLSW  = 5'd5;
  localparam logic [4:0] L_PROT  = 5'd6;
  localparam logic [4:0] L_KNEE  = 5'd7;
  localparam logic [4:0] L_THR   = 5'd8;
  localparam logic [4:0] L_CMP   = 5'd9;
  localparam logic [4:0] L_XCHK  = 5'd10;
  localparam logic [4:0] L_XW    = 5'd11;
  localparam logic [4:0] L_TMUL  = 5'd12;
  localparam logic [4:0] L_TDIV  = 5'd13;
  localparam logic [4:0] L_SQ    = 5'd14;
  localparam logic [4:0] L_TH    = 5'd15;
  localparam logic [4:0] L_THW   = 5'd16;
  localparam logic [4:0] L_SHP   = 5'd17;
  localparam logic [4:0] L_EN    = 5'd18;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  logic [4:0]        state_r;
  logic [SMP_W-1:0]  a_r;
  logic [ENV_W-1:0]  mag_r, fast_env_r, body_env_r, fb_r, bb_r, dlt_r;
  logic [GAIN_W-1:0] cls_r, prot_r, th_r;
  logic [KNEE_W-1:0] knee_r;
  logic [C20_W-1:0]  thr_r, span_r, shaped_r;
  logic [27:0]       u_r, p_r;
  logic [25:0]       m_r;
  logic [2:0]        k_r, sq_r;
  logic [30:0]       e_r;
  logic [NRG_W-1:0]  eterm_r;

  // divider
  logic               div_start, div_done;
  logic [DDW+DQW-1:0] div_num;
  logic [DDW-1:0]     div_den;
  logic [DQW-1:0]     div_quo;

  // datapath
  logic [SMP_W+DRV_W-1:0] mag_p;
  logic [ENV_W+GAIN_W-1:0] fbl_p, bbl_p;
  logic [33:0]       prot_p;
  logic [31:0]       sh_p;
  logic [30:0]       pr_p;
  logic signed [34:0] kq;
  logic [KNEE_W-1:0] knee_nxt;
  logic [37:0]       thr_p, shp_p;
  logic [21:0]       shp_sum;
  logic [55:0]       tm_p;
  logic [63:0]       d3_p, d5_p;
  logic [25:0]       pk;
  logic [61:0]       sq_p;
  logic [30:0]       ec;
  logic [ENV_W-1:0]  diff;
  logic [55:0]       en_p;

  always_comb begin
    mag_p   = a_r * drive;
    fbl_p   = (lf - fast_env_r) * link;
    bbl_p   = (lb - body_env_r) * link;
    prot_p  = cls_r * bias;
    sh_p    = shape * 15'd31457;
    pr_p    = prot_r * 14'd13107;
    kq      = 35'sd2491088896 - $signed({3'b0, sh_p}) - $signed({4'b0, pr_p});
    if (kq < 35'sd64421888) begin
      knee_nxt = 16'd983;
    end else if (kq[31:16] > 16'd40632) begin
      knee_nxt = 16'd40632;
    end else begin
      knee_nxt = kq[31:16];
    end
    thr_p   = ceil20 * (Q16_ONE - {1'b0, knee_r});
    tm_p    = p_r * u_r;
    d3_p    = {38'b0, m_r} * 64'hAAAA_AAAB;
    d5_p    = {38'b0, m_r} * 64'hCCCC_CCCD;
    case (k_r)
      3'd3:    pk = d3_p[58:33];
      3'd4:    pk = {2'b0, m_r[25:2]};
      3'd5:    pk = d5_p[59:34];
      default: pk = {1'b0, m_r[25:1]};
    endcase
    sq_p    = e_r * e_r;
    ec      = (e_r > Q30_ONE) ? Q30_ONE : e_r;
    shp_p   = span_r * th_r;
    shp_sum = {1'b0, thr_r} + shp_p[36:16];
    diff    = (mag_r >= {7'b0, shaped_r}) ? (mag_r - {7'b0, shaped_r})
                                          : ({7'b0, shaped_r} - mag_r);
    en_p    = diff * diff;
  end

  // divider operands: class, tanh argument, tanh quotient
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      L_CLS: begin
        div_start = fb_r > bb_r;
        div_num   = {7'b0, fb_r - bb_r, 16'b0};
        div_den   = {4'b0, fb_r};
      end
      L_XCHK: begin
        div_start = dlt_r < {4'b0, span_r, 3'b0};
        div_num   = {7'b0, dlt_r, 16'b0};
        div_den   = {11'b0, span_r};
      end
      L_TH: begin
        div_start = 1'b1;
        div_num   = {4'b0, Q30_ONE - ec, 16'b0};
        div_den   = {1'b0, Q30_ONE} + {1'b0, ec};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  adsc_div #(.DW(DDW), .QW(DQW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= L_DONE;
      fast_env_r <= '0;
      body_env_r <= '0;
    end else begin
      case (state_r)
        L_DONE: begin
          if (cmd.start) begin
            state_r <= L_MAG;
          end
        end
        L_MAG:   state_r <= L_ENV;
        L_ENV: begin
          if (cmd.en) begin
            fast_env_r <= smooth_to(fast_env_r, mag_r,
                (mag_r > fast_env_r) ? FAST_ATTACK_COEF : FAST_RELEASE_COEF);
            body_env_r <= smooth_to(body_env_r, mag_r,
                (mag_r > body_env_r) ? BODY_ATTACK_COEF : body_rel);
          end
          state_r <= L_BLEND;
        end
        L_BLEND: state_r <= L_CLS;
        L_CLS:   state_r <= (fb_r > bb_r) ? L_CLSW : L_PROT;
        L_CLSW: begin
          if (div_done) begin
            state_r <= L_PROT;
          end
        end
        L_PROT:  state_r <= L_KNEE;
        L_KNEE:  state_r <= L_THR;
        L_THR:   state_r <= L_CMP;
        L_CMP:   state_r <= (mag_r <= {7'b0, thr_r}) ? L_EN : L_XCHK;
        L_XCHK:  state_r <= (dlt_r >= {4'b0, span_r, 3'b0}) ? L_SHP : L_XW;
        L_XW: begin
          if (div_done) begin
            state_r <= L_TMUL;
          end
        end
        L_TMUL:  state_r <= L_TDIV;
        L_TDIV:  state_r <= (k_r == 3'd5) ? L_SQ : L_TMUL;
        L_SQ:    state_r <= (sq_r == 3'd5) ? L_TH : L_SQ;
        L_TH:    state_r <= L_THW;
        L_THW: begin
          if (div_done) begin
            state_r <= L_SHP;
          end
        end
        L_SHP:   state_r <= L_EN;
        L_EN:    state_r <= L_DONE;
        default: state_r <= L_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      L_DONE: begin
        a_r <= sample[SMP_W-1] ? (SMP_W'(0) - sample) : sample;
      end
      L_MAG:   mag_r <= mag_p[SMP_W+DRV_W-1:16];
      L_BLEND: begin
        fb_r <= fast_env_r + fbl_p[ENV_W+15:16];
        bb_r <= body_env_r + bbl_p[ENV_W+15:16];
      end
      L_CLS: begin
        if (!(fb_r > bb_r)) begin
          cls_r <= '0;
        end
      end
      L_CLSW: begin
        if (div_done) begin
          cls_r <= (div_quo > {2'b0, Q16_ONE}) ? Q16_ONE : div_quo[GAIN_W-1:0];
        end
      end
      L_PROT:  prot_r <= prot_p[32:16];
      L_KNEE:  knee_r <= knee_nxt;
      L_THR:   thr_r  <= thr_p[36:16];
      L_CMP: begin
        if (mag_r <= {7'b0, thr_r}) begin
          shaped_r <= mag_r[C20_W-1:0];
        end else begin
          span_r <= (ceil20 > thr_r) ? (ceil20 - thr_r) : C20_W'(1);
          dlt_r  <= mag_r - {7'b0, thr_r};
        end
      end
      L_XCHK: begin
        th_r <= Q16_ONE;  // argument at or above eight: tanh saturates
      end
      L_XW: begin
        u_r <= {div_quo, 9'b0};
        p_r <= {div_quo, 9'b0};
        e_r <= Q30_ONE - {3'b0, div_quo, 9'b0};
        k_r <= 3'd2;
      end
      L_TMUL:  m_r <= tm_p[55:30];
      L_TDIV: begin
        p_r  <= {2'b0, pk};
        e_r  <= k_r[0] ? (e_r - {5'b0, pk}) : (e_r + {5'b0, pk});
        k_r  <= k_r + 3'd1;
        sq_r <= '0;
      end
      L_SQ: begin
        e_r  <= sq_p[60:30];
        sq_r <= sq_r + 3'd1;
      end
      L_THW: begin
        if (div_done) begin
          th_r <= div_quo[GAIN_W-1:0];
        end
      end
      L_SHP: begin
        shaped_r <= (shp_sum > {1'b0, ceil20}) ? ceil20 : shp_sum[C20_W-1:0];
      end
      L_EN:    eterm_r <= en_p[55:24];
      default: begin
      end
    endcase
  end

  assign res.done   = (state_r == L_DONE);
  assign res.fast   = fast_env_r;
  assign res.body   = body_env_r;
  assign res.shaped = shaped_r;
  assign res.cls    = cls_r;
  assign res.knee   = knee_r;
  assign res.eterm  = eterm_r;

endmodule

>>> design/adaptive_soft_clipper.sv
// Top level: register port, control smoothing, trim unit, two lanes and merge.
//
// Usage
//   Input beats (in_left/in_right, one oversampled stereo frame) are taken when
//   in_valid is high and in_stall low. Result beats (out_left, out_right,
//   out_transient_class, out_knee_width, out_clip_energy) leave when out_valid
//   is high and out_stall low. Settings go through the APB-style port at byte
//   address 4*index; write them only while the block is idle.
//   One frame is in work at a time: in_stall stays high from the accepting edge
//   until the merge stage has loaded the result register. Before out_valid
//   rises, the two lanes run side by side, each through one serial divider (a
//   done strobe ends each pass, up to three passes for class, tanh argument
//   and tanh quotient), while the trim unit, when enabled, runs a divide and a
//   17-step square root. The next frame can be taken once the result is
//   loaded.
//   A finished result waits in the output register while the next frame is
//   accepted; the merge stage only holds off while that register is still full
//   and stalled.
//   Reset loads the register defaults, clears envelopes and marks the block
//   unprimed, so the first frame loads the smoothed controls from their targets.
module adaptive_soft_clipper import adsc_pkg::*; #(
  parameter logic [COEF_W-1:0] SMOOTH_COEF       = SMOOTH_COEF_DEF,
  parameter logic [COEF_W-1:0] FAST_ATTACK_COEF  = FAST_ATTACK_COEF_DEF,
  parameter logic [COEF_W-1:0] FAST_RELEASE_COEF = FAST_RELEASE_COEF_DEF,
  parameter logic [COEF_W-1:0] BODY_ATTACK_COEF  = BODY_ATTACK_COEF_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [SMP_W-1:0]  in_left,
  input  logic signed [SMP_W-1:0]  in_right,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [SMP_W-1:0]  out_left,
  output logic signed [SMP_W-1:0]  out_right,
  output logic [GAIN_W-1:0]        out_transient_class,
  output logic [KNEE_W-1:0]        out_knee_width,
  output logic [NRG_W-1:0]         out_clip_energy,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam logic [1:0] T_IDLE   = 2'd0;
  localparam logic [1:0] T_LAUNCH = 2'd1;
  localparam logic [1:0] T_RUN    = 2'd2;
  localparam logic [1:0] T_MERGE  = 2'd3;

  localparam int TQW = 33;   // 2^48 / drive fits 33 bits

  // ---------------- configuration registers ----------------
  logic [DRV_W-1:0]  drive_t_r;
  logic [GAIN_W-1:0] ceil_t_r, shape_t_r, bias_t_r, link_r;
  logic              trim_en_r, mono_r;
  logic [COEF_W-1:0] body_rel_r;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_t_r  <= 20'd172380;
      ceil_t_r   <= 17'd58681;
      shape_t_r  <= 17'd32113;
      bias_t_r   <= 17'd36045;
      link_r     <= 17'd65536;
      trim_en_r  <= 1'b1;
      body_rel_r <= 24'd16774993;
      mono_r     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DRIVE:   drive_t_r  <= pwdata[DRV_W-1:0];
        REG_CEILING: ceil_t_r   <= pwdata[GAIN_W-1:0];
        REG_SHAPE:   shape_t_r  <= pwdata[GAIN_W-1:0];
        REG_BIAS:    bias_t_r   <= pwdata[GAIN_W-1:0];
        REG_LINK:    link_r     <= pwdata[GAIN_W-1:0];
        REG_TRIM:    trim_en_r  <= pwdata[0];
        REG_BODYREL: body_rel_r <= pwdata[COEF_W-1:0];
        REG_MONO:    mono_r     <= pwdata[0];
        default:     mono_r     <= mono_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DRIVE:   prdata = {12'b0, drive_t_r};
      REG_CEILING: prdata = {15'b0, ceil_t_r};
      REG_SHAPE:   prdata = {15'b0, shape_t_r};
      REG_BIAS:    prdata = {15'b0, bias_t_r};
      REG_LINK:    prdata = {15'b0, link_r};
      REG_TRIM:    prdata = {31'b0, trim_en_r};
      REG_BODYREL: prdata = {8'b0, body_rel_r};
      REG_MONO:    prdata = {31'b0, mono_r};
      default:     prdata = '0;
    endcase
  end

  // ---------------- frame control ----------------
  logic [1:0]        st_r;
  logic              primed_r;
  logic [SMP_W-1:0]  left_r, right_r;
  logic              in_acc;

  assign in_stall = (st_r != T_IDLE);
  assign in_acc   = in_valid & ~in_stall;

  // ---------------- control smoothing ----------------
  // Unprimed: start from the target itself, which the step then leaves alone.
  logic [DRV_W-1:0]  drive_s_r;
  logic [GAIN_W-1:0] ceil_s_r, shape_s_r, bias_s_r;
  logic [GAIN_W-1:0] shape_tc, bias_tc, link_c;
  logic [ENV_W-1:0]  drive_nx, ceil_nx, shape_nx, bias_nx;

  always_comb begin
    shape_tc = cap16(shape_t_r);
    bias_tc  = cap16(bias_t_r);
    link_c   = cap16(link_r);
    drive_nx = smooth_to(ENV_W'(primed_r ? drive_s_r : drive_t_r),
                         ENV_W'(drive_t_r), SMOOTH_COEF);
    ceil_nx  = smooth_to(ENV_W'(primed_r ? ceil_s_r : ceil_t_r),
                         ENV_W'(ceil_t_r), SMOOTH_COEF);
    shape_nx = smooth_to(ENV_W'(primed_r ? shape_s_r : shape_tc),
                         ENV_W'(shape_tc), SMOOTH_COEF);
    bias_nx  = smooth_to(ENV_W'(primed_r ? bias_s_r : bias_tc),
                         ENV_W'(bias_tc), SMOOTH_COEF);
  end

  // ceiling scaled by 0.94 into Q.20
  logic [C20_W-1:0] ceil20_r;
  logic [32:0]      ceil_p;
  assign ceil_p = ceil_s_r * 16'd61604;

  // ---------------- trim: isqrt(2^48 / max(drive, 1.0)) ----------------
  logic              tdiv_done;
  logic [TQW-1:0]    tdiv_quo;
  logic [DRV_W-1:0]  drive_floor;
  logic [TQW-1:0]    sv_r;
  logic [TQW:0]      sr_r;
  logic [TQW-1:0]    sbit_r;
  logic              sqrt_busy_r, trim_ok_r;
  logic [GAIN_W-1:0] trim_r;
  logic [TQW:0]      s_sum, sr_nxt;
  logic              s_ge;

  assign drive_floor = (drive_s_r < DRV_W'(65536)) ? DRV_W'(65536) : drive_s_r;

  adsc_div #(.DW(DRV_W), .QW(TQW)) u_tdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start ((st_r == T_LAUNCH) & trim_en_r),
    .num   ((DRV_W+TQW)'(1) << 48),
    .den   (drive_floor),
    .done  (tdiv_done),
    .quo   (tdiv_quo)
  );

  always_comb begin
    s_sum  = sr_r + {1'b0, sbit_r};
    s_ge   = {1'b0, sv_r} >= s_sum;
    sr_nxt = s_ge ? ((sr_r >> 1) + {1'b0, sbit_r}) : (sr_r >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqrt_busy_r <= 1'b0;
      trim_ok_r   <= 1'b0;
    end else begin
      if (st_r == T_LAUNCH) begin
        trim_ok_r <= ~trim_en_r;
      end
      if (tdiv_done) begin
        sqrt_busy_r <= 1'b1;
      end else if (sqrt_busy_r && sbit_r[0]) begin
        sqrt_busy_r <= 1'b0;
        trim_ok_r   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == T_LAUNCH && !trim_en_r) begin
      trim_r <= Q16_ONE;
    end
    if (tdiv_done) begin
      sv_r   <= tdiv_quo;
      sr_r   <= '0;
      sbit_r <= TQW'(1) << (TQW - 1);
    end else if (sqrt_busy_r) begin
      if (s_ge) begin
        sv_r <= sv_r - s_sum[TQW-1:0];
      end
      sr_r   <= sr_nxt;
      sbit_r <= sbit_r >> 2;
      if (sbit_r[0]) begin
        trim_r <= sr_nxt[GAIN_W-1:0];
      end
    end
  end

  // ---------------- lanes ----------------
  lane_cmd_t        cmd0, cmd1;
  lane_res_t        res0, res1;
  logic [ENV_W-1:0] lf, lb;

  assign cmd0.start = (st_r == T_LAUNCH);
  assign cmd0.en    = 1'b1;
  assign cmd1.start = (st_r == T_LAUNCH);
  assign cmd1.en    = ~mono_r;

  // stereo link: largest envelope over the processed channels
  assign lf = (mono_r || res0.fast > res1.fast) ? res0.fast : res1.fast;
  assign lb = (mono_r || res0.body > res1.body) ? res0.body : res1.body;

  adsc_lane #(
    .FAST_ATTACK_COEF  (FAST_ATTACK_COEF),
    .FAST_RELEASE_COEF (FAST_RELEASE_COEF),
    .BODY_ATTACK_COEF  (BODY_ATTACK_COEF)
  ) u_lane0 (
    .clk (clk), .rst_n (rst_n), .cmd (cmd0), .sample (left_r),
    .drive (drive_s_r), .body_rel (body_rel_r), .lf (lf), .lb (lb),
    .link (link_c), .shape (shape_s_r), .bias (bias_s_r), .ceil20 (ceil20_r),
    .res (res0)
  );

  adsc_lane #(
    .FAST_ATTACK_COEF  (FAST_ATTACK_COEF),
    .FAST_RELEASE_COEF (FAST_RELEASE_COEF),
    .BODY_ATTACK_COEF  (BODY_ATTACK_COEF)
  ) u_lane1 (
    .clk (clk), .rst_n (rst_n), .cmd (cmd1), .sample (right_r),
    .drive (drive_s_r), .body_rel (body_rel_r), .lf (lf), .lb (lb),
    .link (link_c), .shape (shape_s_r), .bias (bias_s_r), .ceil20 (ceil20_r),
    .res (res1)
  );

  // ---------------- merge ----------------
  logic              out_valid_r;
  logic              out_free;
  logic [37:0]       clip0_p, clip1_p;
  logic [SMP_W-1:0]  clip0, clip1;
  logic [NRG_W:0]    nrg_sum;

  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    clip0_p = res0.shaped * trim_r;
    clip1_p = res1.shaped * trim_r;
    clip0   = SMP_W'(clip0_p[37:16]);
    clip1   = SMP_W'(clip1_p[37:16]);
    nrg_sum = {1'b0, res0.eterm} + (mono_r ? '0 : {1'b0, res1.eterm});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      drive_s_r   <= 20'd65536;
      ceil_s_r    <= 17'd65536;
      shape_s_r   <= 17'd32768;
      bias_s_r    <= 17'd32768;
    end else begin
      if (st_r == T_MERGE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        T_IDLE: begin
          if (in_acc) begin
            drive_s_r <= drive_nx[DRV_W-1:0];
            ceil_s_r  <= ceil_nx[GAIN_W-1:0];
            shape_s_r <= shape_nx[GAIN_W-1:0];
            bias_s_r  <= bias_nx[GAIN_W-1:0];
            primed_r  <= 1'b1;
            st_r      <= T_LAUNCH;
          end
        end
        T_LAUNCH: st_r <= T_RUN;
        T_RUN: begin
          if (res0.done && res1.done && trim_ok_r) begin
            st_r <= T_MERGE;
          end
        end
        T_MERGE: begin
          if (out_free) begin
            st_r <= T_IDLE;
          end
        end
        default: st_r <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_r  <= in_left;
      right_r <= in_right;
    end
    if (st_r == T_LAUNCH) begin
      ceil20_r <= ceil_p[32:12];
    end
    if (st_r == T_MERGE && out_free) begin
      out_left  <= left_r[SMP_W-1] ? (SMP_W'(0) - clip0) : clip0;
      out_right <= mono_r ? '0 : (right_r[SMP_W-1] ? (SMP_W'(0) - clip1) : clip1);
      out_transient_class <= mono_r ? res0.cls : res1.cls;
      out_knee_width      <= mono_r ? res0.knee : res1.knee;
      out_clip_energy     <= nrg_sum[NRG_W] ? {NRG_W{1'b1}} : nrg_sum[NRG_W-1:0];
    end
  end

  assign out_valid = out_valid_r;

endmodule
